// ----- design/lrusd_pkg.sv -----
// lrusd_pkg: sizes, types and helpers shared by the lru stack distance tracker
// depends on nothing; used by the interfaces, the cells, the encoder and the top level
package lrusd_pkg;

  localparam int FRAMES    = 64;
  localparam int PAGE_BITS = 32;

  localparam int IN_W    = 32;
  localparam int CAP_W   = 7;
  localparam int DEPTH_W = 6;
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // per-cell control from the top level
  typedef struct packed {
    logic valid;  // entry holds a resident page
    logic shift;  // load from the upper neighbor this cycle
  } cell_ctrl_t;

  // low PAGE_BITS bits of the input word, zero extended where wider
  function automatic page_t to_page(logic [IN_W-1:0] word);
    logic [PAGE_BITS+IN_W-1:0] wide;
    wide = {{PAGE_BITS{1'b0}}, word};
    return wide[PAGE_BITS-1:0];
  endfunction

  // stack position reported modulo the depth field
  function automatic logic [DEPTH_W-1:0] to_depth(idx_t idx);
    logic [IDX_W+DEPTH_W-1:0] wide;
    wide = {{DEPTH_W{1'b0}}, idx};
    return wide[DEPTH_W-1:0];
  endfunction

  // capacity saturated at the number of frames
  function automatic cnt_t eff_cap(logic [CAP_W-1:0] cap);
    cnt_t res;
    if (int'(cap) > FRAMES) begin
      res = CNT_W'(FRAMES);
    end else begin
      res = CNT_W'(cap);
    end
    return res;
  endfunction

endpackage

// ----- design/lrusd_if.sv -----
// lrusd_in_if, lrusd_out_if: valid/ready channels of the tracker
// depends on lrusd_pkg for the field widths
interface lrusd_in_if;
  logic                          valid;
  logic                          ready;
  logic [lrusd_pkg::IN_W-1:0]    page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lrusd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [lrusd_pkg::DEPTH_W-1:0]   depth;

  modport source (output valid, output hit, output depth, input ready);
  modport sink   (input valid, input hit, input depth, output ready);
endinterface

// ----- design/lrusd_cell.sv -----
// lrusd_cell: one stack position, holds a page and compares it with the lookup
// depends on lrusd_pkg
module lrusd_cell (
  input  logic                  clk,
  input  lrusd_pkg::cell_ctrl_t ctrl,
  input  lrusd_pkg::page_t      lookup,
  input  lrusd_pkg::page_t      page_up,
  output lrusd_pkg::page_t      page_q,
  output logic                  match
);

  lrusd_pkg::page_t page_r;

  assign match  = ctrl.valid && (page_r == lookup);
  assign page_q = page_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      page_r <= page_up;
    end
  end

endmodule

// ----- design/lrusd_depth_enc.sv -----
// lrusd_depth_enc: turns the match row into a hit flag and a stack position
// depends on lrusd_pkg; the row has at most one bit set
module lrusd_depth_enc (
  input  logic [lrusd_pkg::FRAMES-1:0] match,
  output logic                         hit,
  output lrusd_pkg::idx_t              idx
);

  always_comb begin
    idx = '0;
    for (int i = 0; i < lrusd_pkg::FRAMES; i++) begin
      if (match[i]) begin
        idx = idx | lrusd_pkg::IDX_W'(i);
      end
    end
  end

  assign hit = |match;

endmodule

// ----- design/lru_stack_distance_tracker_unit.sv -----
// lru_stack_distance_tracker_unit: top level, row of stack cells plus control
// depends on lrusd_pkg, lrusd_in_if/lrusd_out_if, lrusd_cell, lrusd_depth_enc
//
//   channel  | dir | payload                  | handshake
//   ---------+-----+--------------------------+----------------------
//   in_ch    | in  | page_number[31:0]        | valid/ready
//   out_ch   | out | hit, depth[5:0]          | valid/ready
//   cfg_*    | in  | cfg_wdata[6:0] capacity  | cfg_we, no back-pressure
//
// one word a cycle: every cell compares against the lookup page at once, the
// match row is encoded to a depth and the cells shift down in the same cycle
// result shows up in the output register in the cycle after the input word
// in_ready drops only while a result waits and out_ready is low
// synchronous active-low reset empties the stack and sets capacity to 64
// a capacity write also empties the stack; there is no clearing pass
module lru_stack_distance_tracker_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  lrusd_in_if.sink                         in_ch,
  lrusd_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [lrusd_pkg::CAP_W-1:0]      cfg_wdata
);

  localparam int FRAMES = lrusd_pkg::FRAMES;

  // control registers
  lrusd_pkg::cnt_t eff_cap_r, eff_cap_nxt;
  lrusd_pkg::cnt_t occ_r, occ_nxt;
  logic            out_valid_r, out_valid_nxt;
  // result payload
  logic                              out_hit_r;
  logic [lrusd_pkg::DEPTH_W-1:0]     out_depth_r;

  logic                  accept;
  lrusd_pkg::page_t      lookup;
  logic [FRAMES-1:0]     match;
  logic                  hit;
  lrusd_pkg::idx_t       hit_idx;
  lrusd_pkg::cell_ctrl_t ctrl [FRAMES];
  lrusd_pkg::page_t      page_q [FRAMES];

  // the output register frees up when its word is taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign lookup      = lrusd_pkg::to_page(in_ch.page_number);

  // per-cell control: valid below occupancy, shift down on accept
  // a hit shifts only the cells at or above the hit position,
  // a miss shifts the whole row and the bottom entry falls off
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      ctrl[i].valid = (lrusd_pkg::CNT_W'(i) < occ_r);
      ctrl[i].shift = accept && (!hit || (lrusd_pkg::IDX_W'(i) <= hit_idx));
    end
  end

  // cell row, page flows from the lookup into cell 0 and downward
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    if (g == 0) begin : g_top
      lrusd_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl[g]),
        .lookup  (lookup),
        .page_up (lookup),
        .page_q  (page_q[g]),
        .match   (match[g])
      );
    end else begin : g_rest
      lrusd_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl[g]),
        .lookup  (lookup),
        .page_up (page_q[g-1]),
        .page_q  (page_q[g]),
        .match   (match[g])
      );
    end
  end

  lrusd_depth_enc u_enc (
    .match (match),
    .hit   (hit),
    .idx   (hit_idx)
  );

  // occupancy grows on a miss until the effective capacity is reached; a capacity write clears it
  always_comb begin
    eff_cap_nxt   = eff_cap_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (!hit && (occ_r < eff_cap_r)) begin
        occ_nxt = occ_r + lrusd_pkg::CNT_W'(1);
      end
    end
    if (cfg_we) begin
      eff_cap_nxt = lrusd_pkg::eff_cap(cfg_wdata);
      occ_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_cap_r   <= lrusd_pkg::eff_cap(lrusd_pkg::CAP_RESET);
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      eff_cap_r   <= eff_cap_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, depth is zero on a miss
  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r   <= hit;
      out_depth_r <= hit ? lrusd_pkg::to_depth(hit_idx) : '0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;
  assign out_ch.depth = out_depth_r;

endmodule
